// ===== hw/rtl/per_host_rtt_stats_table_macros.svh =====
// ----------------------------------------------------------------------------
// per_host_rtt_stats_table_macros.svh
// Assertion helpers shared by the RTT statistics table RTL.
// ----------------------------------------------------------------------------
`ifndef PER_HOST_RTT_STATS_TABLE_MACROS_SVH
`define PER_HOST_RTT_STATS_TABLE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PRST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PRST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/prst_pkg.sv =====
// ----------------------------------------------------------------------------
// prst_pkg
// Shared types and constants of the per-host RTT statistics table.
// ----------------------------------------------------------------------------
package prst_pkg;

    // Field widths
    localparam int TS_W   = 64;
    localparam int ADDR_W = 32;
    localparam int RTT_W  = 32;
    localparam int CNT_W  = 31;
    localparam int MIN_W  = 31;
    localparam int SLOT_W = 7;

    // Tick-to-microsecond divide
    localparam int               REM_W        = 10;
    localparam logic [REM_W-1:0] TICKS_PER_US = 10'd1000;
    // Magnitudes from here up give a quotient of 2^31 or more
    localparam logic [TS_W-1:0]  SAT_TICKS    = 64'd2147483648000;
    // Below that bound: (mag >> 3) / 125 as a multiply by ceil(2^45 / 125)
    localparam int                 DIV_PRE_W   = 3;
    localparam int                 DIV_X_W     = 38;
    localparam int                 DIV_H_W     = 19;
    localparam int                 RECIP_W     = 39;
    localparam logic [RECIP_W-1:0] RECIP_125   = 39'd281474976711;
    localparam int                 RECIP_SHIFT = 45;
    localparam int                 PROD_W      = DIV_X_W + RECIP_W;

    // Register file
    localparam int               CFG_ADDR_W      = 3;
    localparam int               CFG_DATA_W      = 32;
    localparam logic             REG_MIN_START   = 1'b0;
    localparam logic [MIN_W-1:0] MIN_START_RESET = 31'd10000000;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [RTT_W-1:0] RTT_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [RTT_W-1:0] RTT_NEG_SAT = 32'h8000_0000;

    // One table entry
    typedef struct packed {
        logic [ADDR_W-1:0]        key;
        logic signed [RTT_W-1:0]  min_v;
        logic signed [RTT_W-1:0]  max_v;
        logic [CNT_W-1:0]         count;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic search;
        logic claim;
        logic calc_rtt;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic addr_zero;
        logic hit;
        logic miss_done;
        logic full;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/prst_div.sv =====
// ----------------------------------------------------------------------------
// prst_div
// Divide a 64-bit magnitude by 1000 with a reciprocal multiply built from
// partial products; quotients of 2^31 and up come back as all ones.
// ----------------------------------------------------------------------------
module prst_div import prst_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [TS_W-1:0] i_dividend,
    output logic            o_busy,
    output logic [TS_W-1:0] o_quotient
);

    localparam int STEP_W  = 2;
    localparam int MUL_A_W = DIV_H_W;
    localparam int MUL_B_W = RECIP_W - DIV_H_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam logic [STEP_W-1:0]  STEP_LAST = 2'd3;
    localparam logic [MUL_B_W-1:0] RC_LO = {1'b0, RECIP_125[DIV_H_W-1:0]};
    localparam logic [MUL_B_W-1:0] RC_HI = RECIP_125[RECIP_W-1:DIV_H_W];

    logic [DIV_X_W-1:0] r_x;
    logic               r_big;
    logic [PROD_W-1:0]  r_acc;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    logic [PROD_W-1:0]  w_term;

    // Pick one partial product per step
    always_comb begin
        case (r_step)
            2'd0: begin
                w_mul_a = r_x[DIV_H_W-1:0];
                w_mul_b = RC_LO;
            end
            2'd1: begin
                w_mul_a = r_x[DIV_H_W-1:0];
                w_mul_b = RC_HI;
            end
            2'd2: begin
                w_mul_a = r_x[DIV_X_W-1:DIV_H_W];
                w_mul_b = RC_LO;
            end
            default: begin
                w_mul_a = r_x[DIV_X_W-1:DIV_H_W];
                w_mul_b = RC_HI;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Place the partial product at its weight
    always_comb begin
        case (r_step)
            2'd0: begin
                w_term = PROD_W'(w_prod);
            end
            2'd1: begin
                w_term = PROD_W'(w_prod) << DIV_H_W;
            end
            2'd2: begin
                w_term = PROD_W'(w_prod) << DIV_H_W;
            end
            default: begin
                w_term = PROD_W'(w_prod) << (2 * DIV_H_W);
            end
        endcase
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Capture the operand and flag saturation, then accumulate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_dividend[DIV_X_W+DIV_PRE_W-1:DIV_PRE_W];
            r_big <= (i_dividend >= SAT_TICKS);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_big ? '1 : TS_W'(r_acc[PROD_W-1:RECIP_SHIFT]);

endmodule

// ===== hw/rtl/prst_dp.sv =====
// ----------------------------------------------------------------------------
// prst_dp
// Datapath: request capture, entry memory with sequential key search,
// round-trip conversion, statistics update and the result register.
// ----------------------------------------------------------------------------
module prst_dp import prst_pkg::*; #(
    parameter int NUM_HOSTS = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic [MIN_W-1:0]        i_min_start,
    input  logic signed [TS_W-1:0]  i_rx_time,
    input  logic signed [TS_W-1:0]  i_tx_time,
    input  logic [ADDR_W-1:0]       i_host_address,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_stored,
    output logic [SLOT_W-1:0]       o_slot,
    output logic signed [RTT_W-1:0] o_rtt_us,
    output logic signed [RTT_W-1:0] o_min_us,
    output logic signed [RTT_W-1:0] o_max_us,
    output logic [CNT_W-1:0]        o_report_count
);

    localparam int IDX_W  = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;
    localparam int FILL_W = $clog2(NUM_HOSTS + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(NUM_HOSTS);

    // Request
    logic [TS_W-1:0]   r_rx;
    logic [TS_W-1:0]   r_tx;
    logic [ADDR_W-1:0] r_addr;
    logic              r_neg;

    // Search
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic              r_rd_valid;
    logic [IDX_W-1:0]  r_rd_idx;
    t_entry            r_rd_entry;
    logic              w_issue;
    logic              w_hit;

    // Selected entry
    logic [IDX_W-1:0]  r_slot;
    t_entry            r_entry;
    logic              r_keep;
    logic              r_new;

    // Round trip
    logic [TS_W-1:0]         w_mag;
    logic                    w_busy;
    logic [TS_W-1:0]         w_quot;
    logic                    w_q_big;
    logic [RTT_W-1:0]        w_q_low;
    logic signed [RTT_W-1:0] w_rtt;
    logic signed [RTT_W-1:0] r_rtt;

    // Update
    logic signed [RTT_W-1:0]  w_new_min;
    logic signed [RTT_W-1:0]  w_new_max;
    logic [CNT_W-1:0]         w_new_cnt;
    t_entry                   w_wr_entry;
    logic                     w_we;
    logic [SLOT_W+IDX_W-1:0]  w_slot_ext;

    // Result register
    logic                    r_out_valid;
    logic                    r_out_stored;
    logic [SLOT_W-1:0]       r_out_slot;
    logic signed [RTT_W-1:0] r_out_rtt;
    logic signed [RTT_W-1:0] r_out_min;
    logic signed [RTT_W-1:0] r_out_max;
    logic [CNT_W-1:0]        r_out_cnt;

    t_entry mem [NUM_HOSTS];

    // Capture the request and the sign of the round trip
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rx   <= i_rx_time;
            r_tx   <= i_tx_time;
            r_addr <= i_host_address;
            r_neg  <= (i_rx_time < i_tx_time);
        end
    end

    // Convert ticks to microseconds
    assign w_mag = r_neg ? (r_tx - r_rx) : (r_rx - r_tx);

    prst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag),
        .o_busy     (w_busy),
        .o_quotient (w_quot)
    );

    assign w_q_big = |w_quot[TS_W-1:RTT_W-1];
    assign w_q_low = {1'b0, w_quot[RTT_W-2:0]};

    always_comb begin
        if (!r_neg) begin
            w_rtt = w_q_big ? RTT_POS_SAT : w_q_low;
        end else begin
            w_rtt = w_q_big ? RTT_NEG_SAT : (~w_q_low + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_rtt) begin
            r_rtt <= w_rtt;
        end
    end

    // Walk the filled entries, one read a cycle
    assign w_issue = i_cmd.search && (r_idx != r_fill);
    assign w_hit   = r_rd_valid && (r_rd_entry.key == r_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_slot] <= w_wr_entry;
        end
        if (w_issue) begin
            r_rd_entry <= mem[r_idx[IDX_W-1:0]];
            r_rd_idx   <= r_idx[IDX_W-1:0];
        end
    end

    // Hold the matched entry, or build a fresh one for an unknown host
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
            r_new  <= 1'b0;
        end else if (i_cmd.load) begin
            r_keep <= 1'b0;
            r_new  <= 1'b0;
        end else if (i_cmd.search && w_hit) begin
            r_keep <= 1'b1;
        end else if (i_cmd.claim) begin
            r_keep <= 1'b1;
            r_new  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search && w_hit) begin
            r_slot  <= r_rd_idx;
            r_entry <= r_rd_entry;
        end else if (i_cmd.claim) begin
            r_slot        <= r_fill[IDX_W-1:0];
            r_entry.key   <= r_addr;
            r_entry.min_v <= {1'b0, i_min_start};
            r_entry.max_v <= '0;
            r_entry.count <= '0;
        end
    end

    // Fold this round trip into the entry
    assign w_new_min = (r_rtt < r_entry.min_v) ? r_rtt : r_entry.min_v;
    assign w_new_max = (r_rtt > r_entry.max_v) ? r_rtt : r_entry.max_v;
    assign w_new_cnt = (r_entry.count == COUNT_MAX) ? r_entry.count
                                                    : (r_entry.count + 1'b1);

    assign w_wr_entry.key   = r_entry.key;
    assign w_wr_entry.min_v = w_new_min;
    assign w_wr_entry.max_v = w_new_max;
    assign w_wr_entry.count = w_new_cnt;
    assign w_we             = i_cmd.emit && r_keep;
    assign w_slot_ext       = {{SLOT_W{1'b0}}, r_slot};

    // Advance the fill level when a new entry is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_we && r_new) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_stored <= r_keep;
            if (r_keep) begin
                r_out_slot <= w_slot_ext[SLOT_W-1:0];
                r_out_rtt  <= r_rtt;
                r_out_min  <= w_new_min;
                r_out_max  <= w_new_max;
                r_out_cnt  <= w_new_cnt;
            end else begin
                r_out_slot <= '0;
                r_out_rtt  <= '0;
                r_out_min  <= '0;
                r_out_max  <= '0;
                r_out_cnt  <= '0;
            end
        end
    end

    // Status back to the controller
    assign o_stat.addr_zero = (r_addr == '0);
    assign o_stat.hit       = w_hit;
    assign o_stat.miss_done = !r_rd_valid && (r_idx == r_fill);
    assign o_stat.full      = (r_fill == FILL_FULL);
    assign o_stat.div_busy  = w_busy;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_stored       = r_out_stored;
    assign o_slot         = r_out_slot;
    assign o_rtt_us       = r_out_rtt;
    assign o_min_us       = r_out_min;
    assign o_max_us       = r_out_max;
    assign o_report_count = r_out_cnt;

endmodule

// ===== hw/rtl/prst_ctrl.sv =====
// ----------------------------------------------------------------------------
// prst_ctrl
// Controller: sequences capture, key search, entry claim, round-trip
// conversion and result emission for one request at a time.
// ----------------------------------------------------------------------------
module prst_ctrl import prst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_CALC   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.addr_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_CALC;
                end else if (i_stat.miss_done) begin
                    if (i_stat.full) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.claim = 1'b1;
                        n_state     = S_CALC;
                    end
                end
            end
            S_CALC: begin
                if (!i_stat.div_busy) begin
                    o_cmd.calc_rtt = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ===== hw/rtl/per_host_rtt_stats_table.sv =====
// ----------------------------------------------------------------------------
// per_host_rtt_stats_table
// Per-host round-trip statistics table with an APB-style register port.
// ----------------------------------------------------------------------------
// A request carries receive time, transmit time and host address on the
// valid/ready input channel. Each request yields exactly one result on the
// valid/ready output channel: stored flag, slot, round trip in microseconds,
// and the host's minimum, maximum and report count after the update.
// Address zero and unknown hosts arriving at a full table give stored = 0
// and all other fields zero.
// Address zero skips the search and the divide. Otherwise the key search
// reads one entry per cycle from slot 0 until the key matches or every
// filled entry has been read, and the 4-step reciprocal divide by 1000 runs
// beside it. A stored result is emitted once both are done, a full-table
// drop as soon as the search ends. One request is in work at a time; the
// next one is accepted once the previous result sits in the output
// register. A stalled receiver holds the result; the block then finishes
// at most one more request and waits with it until the output register frees.
// Reset empties the table (fill level zero) and sets min_start to 10000000;
// no clearing pass runs. min_start sits at byte address 0.
// ----------------------------------------------------------------------------
`include "per_host_rtt_stats_table_macros.svh"

module per_host_rtt_stats_table import prst_pkg::*; #(
    parameter int NUM_HOSTS = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    // Request channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [TS_W-1:0]  i_rx_time,
    input  logic signed [TS_W-1:0]  i_tx_time,
    input  logic [ADDR_W-1:0]       i_host_address,
    // Result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_stored,
    output logic [SLOT_W-1:0]       o_slot,
    output logic signed [RTT_W-1:0] o_rtt_us,
    output logic signed [RTT_W-1:0] o_min_us,
    output logic signed [RTT_W-1:0] o_max_us,
    output logic [CNT_W-1:0]        o_report_count
);

    logic [MIN_W-1:0] r_min_start;
    logic             w_reg_idx;
    logic             w_wr;
    t_cmd             s_cmd;
    t_stat            s_stat;

    // Register port: word index from the byte address
    assign w_reg_idx = paddr[2];
    assign w_wr      = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_start <= MIN_START_RESET;
        end else if (w_wr && (w_reg_idx == REG_MIN_START)) begin
            r_min_start <= pwdata[MIN_W-1:0];
        end
    end

    assign prdata = (w_reg_idx == REG_MIN_START) ? {1'b0, r_min_start} : '0;

    prst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd)
    );

    prst_dp #(
        .NUM_HOSTS (NUM_HOSTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_stat         (s_stat),
        .i_min_start    (r_min_start),
        .i_rx_time      (i_rx_time),
        .i_tx_time      (i_tx_time),
        .i_host_address (i_host_address),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_stored       (o_stored),
        .o_slot         (o_slot),
        .o_rtt_us       (o_rtt_us),
        .o_min_us       (o_min_us),
        .o_max_us       (o_max_us),
        .o_report_count (o_report_count)
    );

    // Checks
    `PRST_ASSERT_NOW(a_claim_not_full, s_cmd.claim, !s_stat.full,
                     "entry claimed in full table")
    `PRST_ASSERT_NOW(a_drop_zeroes, o_valid && !o_stored,
                     (o_slot == 0) && (o_rtt_us == 0) && (o_min_us == 0) &&
                     (o_max_us == 0) && (o_report_count == 0),
                     "dropped request has nonzero fields")
    `PRST_ASSERT_NOW(a_stats_order, o_valid && o_stored,
                     ($signed(o_min_us) <= $signed(o_rtt_us)) &&
                     ($signed(o_rtt_us) <= $signed(o_max_us)) &&
                     (o_report_count != 0),
                     "stored result out of order")
    `PRST_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready,
                      !o_ready && !s_cmd.emit, "request accepted twice")

endmodule

// ===== tb/tb_per_host_rtt_stats_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_host_rtt_stats_table
// Self-checking bench for the per-host RTT statistics table.
// ----------------------------------------------------------------------------
// Round-trip requests go in on the valid/ready request channel. A scoreboard
// keeps its own copy of the host table and the min_start register, and
// predicts one result per accepted request. Results are compared in order.
// A short directed run covers address zero, saturation at both ends,
// truncation toward zero and a round trip above the starting minimum. Random
// phases follow, each with its own min_start, until the table fills and
// further unknown hosts are dropped. Both channels idle at random; the
// receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_per_host_rtt_stats_table import prst_pkg::*; ();

    localparam int NUM_HOSTS = 128;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned LONG_STALL_CYCLES = 600;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned NO_STALL = 32'hFFFF_FFFF;
    // min_start is register 0; the next word has no register behind it
    localparam logic [CFG_ADDR_W-1:0] MIN_START_ADDR = CFG_ADDR_W'(4 * REG_MIN_START);
    localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_ADDR = CFG_ADDR_W'(4 * (REG_MIN_START + 1));

    typedef struct packed {
        logic              stored;
        logic [SLOT_W-1:0] slot;
        logic [RTT_W-1:0]  rtt_us;
        logic [RTT_W-1:0]  min_us;
        logic [RTT_W-1:0]  max_us;
        logic [CNT_W-1:0]  report_count;
    } t_rtt_result;

    // Host table mirror and the queue of results still to arrive
    class t_rtt_scoreboard;
        logic [MIN_W-1:0]        claim_min;
        int unsigned             hosts_used;
        logic [ADDR_W-1:0]       host_key [NUM_HOSTS];
        logic signed [RTT_W-1:0] host_min [NUM_HOSTS];
        logic signed [RTT_W-1:0] host_max [NUM_HOSTS];
        logic [CNT_W-1:0]        host_reports [NUM_HOSTS];
        t_rtt_result             expected_q [$];
        int unsigned             errors;

        function new();
            claim_min = MIN_START_RESET;
            hosts_used = 0;
            errors = 0;
        endfunction

        // Exact (rx - tx) / 1000, truncated toward zero, clamped to 32 bits
        function logic signed [RTT_W-1:0] micro_round_trip(logic [TS_W-1:0] rx,
                                                           logic [TS_W-1:0] tx);
            logic [TS_W:0] diff;
            logic [TS_W:0] mag;
            logic [TS_W:0] quo;
            diff = {rx[TS_W-1], rx} - {tx[TS_W-1], tx};
            mag = diff[TS_W] ? (~diff + 1'b1) : diff;
            quo = mag / TICKS_PER_US;
            if (!diff[TS_W]) begin
                return (quo > 65'h7FFF_FFFF) ? RTT_POS_SAT : quo[RTT_W-1:0];
            end
            return (quo >= 65'h8000_0000) ? RTT_NEG_SAT : (~quo[RTT_W-1:0] + 1'b1);
        endfunction

        // Look up or claim the host entry, update it and queue the result
        function void note_report(logic [TS_W-1:0] rx, logic [TS_W-1:0] tx,
                                  logic [ADDR_W-1:0] host);
            t_rtt_result res;
            int unsigned idx;
            bit found;
            logic signed [RTT_W-1:0] rtt;
            res = '0;
            found = 1'b0;
            idx = 0;
            if (host != '0) begin
                for (int unsigned i = 0; i < hosts_used; i++) begin
                    if (!found && host_key[i] == host) begin
                        found = 1'b1;
                        idx = i;
                    end
                end
                if (!found && hosts_used < NUM_HOSTS) begin
                    idx = hosts_used;
                    host_key[idx] = host;
                    host_min[idx] = {1'b0, claim_min};
                    host_max[idx] = '0;
                    host_reports[idx] = '0;
                    hosts_used++;
                    found = 1'b1;
                end
                if (found) begin
                    rtt = micro_round_trip(rx, tx);
                    if (rtt < host_min[idx]) host_min[idx] = rtt;
                    if (rtt > host_max[idx]) host_max[idx] = rtt;
                    if (host_reports[idx] != COUNT_MAX) host_reports[idx] = host_reports[idx] + 1'b1;
                    res.stored = 1'b1;
                    res.slot = idx[SLOT_W-1:0];
                    res.rtt_us = rtt;
                    res.min_us = host_min[idx];
                    res.max_us = host_max[idx];
                    res.report_count = host_reports[idx];
                end
            end
            expected_q.push_back(res);
        endfunction

        // Compare one delivered result against the oldest prediction
        function void check_result(t_rtt_result act);
            t_rtt_result exp_res;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result with no request pending");
                return;
            end
            exp_res = expected_q.pop_front();
            if (act !== exp_res) begin
                errors++;
                if (errors <= 10) begin
                    $display("result mismatch: stored %0d/%0d slot %0d/%0d rtt %0d/%0d",
                             exp_res.stored, act.stored, exp_res.slot, act.slot,
                             $signed(exp_res.rtt_us), $signed(act.rtt_us));
                    $display("  min %0d/%0d max %0d/%0d count %0d/%0d (expected/actual)",
                             $signed(exp_res.min_us), $signed(act.min_us),
                             $signed(exp_res.max_us), $signed(act.max_us),
                             exp_res.report_count, act.report_count);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [TS_W-1:0]  i_rx_time;
    logic signed [TS_W-1:0]  i_tx_time;
    logic [ADDR_W-1:0]       i_host_address;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic                    o_stored;
    logic [SLOT_W-1:0]       o_slot;
    logic signed [RTT_W-1:0] o_rtt_us;
    logic signed [RTT_W-1:0] o_min_us;
    logic signed [RTT_W-1:0] o_max_us;
    logic [CNT_W-1:0]        o_report_count;

    t_rtt_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          long_stall_req = 1'b0;
    bit          long_stall_done = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    per_host_rtt_stats_table #(
        .NUM_HOSTS(NUM_HOSTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_rx_time(i_rx_time),
        .i_tx_time(i_tx_time),
        .i_host_address(i_host_address),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_stored(o_stored),
        .o_slot(o_slot),
        .o_rtt_us(o_rtt_us),
        .o_min_us(o_min_us),
        .o_max_us(o_max_us),
        .o_report_count(o_report_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_per_host_rtt_stats_table NOT OK");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            i_ready <= 1'b0;
            stall_left <= LONG_STALL_CYCLES;
            long_stall_done <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check results first, then record newly accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result({o_stored, o_slot, o_rtt_us, o_min_us, o_max_us,
                                 o_report_count});
            end
            if (i_valid && o_ready) sb.note_report(i_rx_time, i_tx_time, i_host_address);
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_report(input logic [TS_W-1:0] rx, input logic [TS_W-1:0] tx,
                               input logic [ADDR_W-1:0] host);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_time <= rx;
        i_tx_time <= tx;
        i_host_address <= host;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Mostly known hosts with realistic round trips, some new hosts and noise
    task automatic send_random_report(input int unsigned new_pct);
        logic [TS_W-1:0]   tx;
        logic [TS_W-1:0]   delta;
        logic [ADDR_W-1:0] host;
        logic [31:0]       r;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            host = '0;
        end else if (pick < 4 + new_pct || sb.hosts_used == 0) begin
            host = $urandom;
        end else begin
            host = sb.host_key[$urandom_range(sb.hosts_used - 1)];
        end
        tx = {$urandom, $urandom};
        r = $urandom;
        pick = $urandom_range(99);
        if (pick < 55) begin
            delta = 64'($urandom_range(60_000_000)) - 64'd20_000_000;
        end else if (pick < 75) begin
            delta = {{32{r[31]}}, r} * 64'($urandom_range(1500, 1));
        end else if (pick < 90) begin
            // land within a few microseconds of either clamp point
            delta = (64'd2147483645 + 64'($urandom_range(4))) * 64'd1000
                    + 64'($urandom_range(999));
            if (r[0]) delta = -delta - 64'd1000;
        end else begin
            delta = {$urandom, $urandom};
        end
        send_report(tx + delta, tx, host);
    endtask

    task automatic run_phase(input int unsigned n_reports, input int unsigned new_pct,
                             input int unsigned stall_at);
        for (int unsigned n = 0; n < n_reports; n++) begin
            if (n == stall_at) long_stall_req = 1'b1;
            send_random_report(new_pct);
        end
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == MIN_START_ADDR) sb.claim_min = data[MIN_W-1:0];
        @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_rx_time <= '0;
        i_tx_time <= '0;
        i_host_address <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners with the reset min_start
        send_idle_pct = 34;
        recv_idle_pct = 81;
        send_report(64'd0, 64'd0, 32'd0);
        send_report(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 32'd0);
        send_report(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
        send_report(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_report(64'd1000, 64'd0, 32'd1);
        send_report(64'd0, 64'd999, 32'd1);
        send_report(64'd0, 64'd1000, 32'd1);
        send_report(64'd2147483647999, 64'd0, 32'd1);
        send_report(64'd2147483648000, 64'd0, 32'd1);
        send_report(64'd0, 64'd2147483647999, 32'h8000_0000);
        send_report(64'd0, 64'd2147483648999, 32'h8000_0000);
        send_report(64'd0, 64'd2147483649000, 32'h8000_0000);
        send_report(-64'sd5, -64'sd5, 32'h5555_5555);
        send_report(64'd20_000_000_000, 64'd0, 32'hAAAA_AAAA);
        send_report(64'd15_000_000_000, 64'd0, 32'hAAAA_AAAA);
        send_report(-64'sd1, 64'd0, 32'h1234_5678);
        send_report(64'd123_456_789, -64'sd987_654_321, 32'h5555_5555);
        send_report(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'd0);
        drain();

        // Top of range; bit 31 of the write data is beyond the register
        apb_write(MIN_START_ADDR, 32'hFFFF_FFFF);
        apb_write(UNUSED_REG_ADDR, $urandom);
        run_phase(260, 6, NO_STALL);
        drain();

        send_idle_pct = 81;
        recv_idle_pct = 34;
        apb_write(MIN_START_ADDR, 32'd0);
        run_phase(260, 6, NO_STALL);
        drain();

        apb_write(MIN_START_ADDR, $urandom);
        run_phase(260, 6, NO_STALL);
        drain();

        // Full rate; the long receiver hold backs up the request side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(MIN_START_ADDR, 32'd1);
        run_phase(260, 6, 50);
        drain();

        // Claim the rest of the table and keep going once it is full
        apb_write(MIN_START_ADDR, $urandom_range(50_000));
        run_phase(280, 45, NO_STALL);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_per_host_rtt_stats_table OK");
        end else begin
            $display("tb_per_host_rtt_stats_table NOT OK");
        end
        $finish;
    end

endmodule
